// ===== src/smrs_pkg.sv =====
package smrs_pkg;

  // Store size and field widths
  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int KIND_W   = 4;
  localparam int ARG_W    = 11;
  localparam int RANK_W   = 11;
  localparam int SUM_W    = 42;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > ARG_W) ? CNT_W : ARG_W;

  // Radix-4 reduction tree shape
  localparam int LEVELS   = ($clog2(CAPACITY) + 1) / 2;
  localparam int LEAVES   = 1 << (2 * LEVELS);
  localparam int NODES    = LEAVES / 4;
  localparam int LVL_W    = $clog2(LEVELS + 1);

  // Stream payload widths
  localparam int IN_FIELDS_W  = KEY_W + 1 + ARG_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + RANK_W + KEY_W + SUM_W + 1 + RANK_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INS   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ERA   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CLR   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_RANK  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SEL   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_FIRST = 4'd5;
  localparam logic [KIND_W-1:0] KIND_FROM  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_BELOW = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ATUP  = 4'd8;

  // Operation broadcast to every cell
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    logic [ARG_W-1:0]        carg;
    logic [CNT_W-1:0]        count;
  } op_t;

  // Shift control applied at commit
  typedef struct packed {
    logic ins;
    logic era;
  } ctl_t;

  // Partial result carried through the tree
  typedef struct packed {
    logic [CNT_W-1:0]        lt;
    logic                    eq;
    logic signed [SUM_W-1:0] sum;
  } node_t;

  function automatic node_t node_add4(input node_t a, input node_t b,
                                      input node_t c, input node_t d);
    node_t r;
    r.lt  = a.lt + b.lt + c.lt + d.lt;
    r.eq  = a.eq | b.eq | c.eq | d.eq;
    r.sum = a.sum + b.sum + c.sum + d.sum;
    return r;
  endfunction

endpackage

// ===== src/sorted_multiset_rank_sum.sv =====
// Sorted multiset of up to CAPACITY signed 32-bit keys, kept in ascending
// order in a row of cells. Each item carries one operation (insert, erase one
// copy, clear, rank, select, first-k sum, from-k sum, sum below a key, sum at
// or above a key) and yields exactly one result item with membership, rank,
// selected key, sum, full-store status and the occupancy after the operation.
// Every cell compares its key with the operand in parallel; rank, presence,
// selection and sums are all gathered by a registered radix-4 adder tree of
// LEVELS levels (5 at 1024 entries), and inserts and erases then shift the
// cells by one place. The result is registered in a commit step once the
// tree's register levels have settled. The next item is taken in the cycle
// after that result is registered; a stalled output delays the commit.
// The result sits in an output register, so the next item can be accepted
// while it waits.
module sorted_multiset_rank_sum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key [31:0], unique_only [32], count_arg [43:33], zero fill above
  input  logic [smrs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind [3:0]
  input  logic [smrs_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // found [0], rank [11:1], key_out [43:12], sum_out [85:44], status [86],
  // occupancy [97:87], zero fill above
  output logic [smrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import smrs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]              state;
  logic [LVL_W-1:0]        run_cnt;
  logic [KIND_W-1:0]       op_kind;
  logic signed [KEY_W-1:0] op_key;
  logic                    op_uniq;
  logic [ARG_W-1:0]        op_carg;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;

  op_t                     cell_op;
  ctl_t                    cell_ctl;
  logic signed [KEY_W-1:0] cell_key  [CAPACITY];
  logic                    cell_lt   [CAPACITY];
  logic                    cell_eq   [CAPACITY];
  logic signed [SUM_W-1:0] cell_term [CAPACITY];
  node_t                   root;

  logic                    accept;
  logic                    commit;
  logic                    present;
  logic                    full;
  logic                    dup_skip;
  logic                    ins_ok;
  logic                    era_ok;
  logic                    res_found;
  logic [RANK_W-1:0]       res_rank;
  logic signed [KEY_W-1:0] res_key;
  logic signed [SUM_W-1:0] res_sum;
  logic                    res_status;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Broadcast the held operation to the cells
  assign cell_op = '{kind: op_kind, key: op_key, carg: op_carg, count: count};

  // Row of cells, each wired to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic                    left_lt;
    logic signed [KEY_W-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = op_key;
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    smrs_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .op       (cell_op),
      .ctl      (cell_ctl),
      .prev_key (left_key),
      .prev_lt  (left_lt),
      .next_key (right_key),
      .key_q    (cell_key[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i]),
      .term     (cell_term[i])
    );
  end

  smrs_tree u_tree (
    .clk  (clk),
    .lt   (cell_lt),
    .eq   (cell_eq),
    .term (cell_term),
    .root (root)
  );

  // Decide the update from the reduced results
  assign present  = root.eq;
  assign full     = (count == CNT_W'(CAPACITY));
  assign dup_skip = op_uniq && present;
  assign ins_ok   = (op_kind == KIND_INS) && !dup_skip && !full;
  assign era_ok   = (op_kind == KIND_ERA) && present;

  assign cell_ctl = '{ins: commit && ins_ok, era: commit && era_ok};

  always_comb begin
    count_next = count;
    if (op_kind == KIND_CLR) begin
      count_next = '0;
    end else if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (era_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Form the result fields
  always_comb begin
    res_found  = 1'b0;
    res_rank   = '0;
    res_key    = '0;
    res_sum    = '0;
    res_status = 1'b0;
    case (op_kind)
      KIND_INS: begin
        res_found  = present;
        res_rank   = RANK_W'(root.lt);
        res_status = !dup_skip && full;
      end
      KIND_ERA: begin
        res_found = present;
        res_rank  = RANK_W'(root.lt);
      end
      KIND_RANK: begin
        res_found = present;
        res_rank  = RANK_W'(root.lt);
      end
      KIND_SEL: begin
        res_found = CMP_W'(op_carg) < CMP_W'(count);
        res_key   = root.sum[KEY_W-1:0];
      end
      KIND_FIRST, KIND_FROM: begin
        res_sum = root.sum;
      end
      KIND_BELOW, KIND_ATUP: begin
        res_found = present;
        res_rank  = RANK_W'(root.lt);
        res_sum   = root.sum;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // Sequence: take an item, let the tree settle, then commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      run_cnt <= '0;
      count   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state   <= S_RUN;
            run_cnt <= '0;
          end
        end
        S_RUN: begin
          if (run_cnt == LVL_W'(LEVELS - 1)) begin
            state <= S_DONE;
          end
          run_cnt <= run_cnt + LVL_W'(1);
        end
        S_DONE: begin
          if (commit) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the operation fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= s_axis_tuser;
      op_key  <= s_axis_tdata[KEY_W-1:0];
      op_uniq <= s_axis_tdata[KEY_W];
      op_carg <= s_axis_tdata[KEY_W+ARG_W:KEY_W+1];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tdata <= OUT_DATA_W'({RANK_W'(count_next), res_status, res_sum,
                                   res_key, res_rank, res_found});
    end
  end

endmodule

// ===== src/smrs_cell.sv =====
module smrs_cell (
  input  logic                              clk,
  input  logic [smrs_pkg::IDX_W-1:0]        idx,
  input  smrs_pkg::op_t                     op,
  input  smrs_pkg::ctl_t                    ctl,
  input  logic signed [smrs_pkg::KEY_W-1:0] prev_key,
  input  logic                              prev_lt,
  input  logic signed [smrs_pkg::KEY_W-1:0] next_key,
  output logic signed [smrs_pkg::KEY_W-1:0] key_q,
  output logic                              lt,
  output logic                              eq,
  output logic signed [smrs_pkg::SUM_W-1:0] term
);
  import smrs_pkg::*;

  logic             valid;
  logic [CMP_W-1:0] idx_e;
  logic [CMP_W-1:0] carg_e;
  logic             take;

  // Compare the held key with the operand
  assign idx_e  = CMP_W'(idx);
  assign carg_e = CMP_W'(op.carg);
  assign valid  = CMP_W'(idx) < CMP_W'(op.count);
  assign lt     = valid && (key_q < op.key);
  assign eq     = valid && (key_q == op.key);

  // Pick whether this cell contributes to the sum
  always_comb begin
    case (op.kind)
      KIND_SEL:   take = valid && (idx_e == carg_e);
      KIND_FIRST: take = valid && (idx_e < carg_e);
      KIND_FROM:  take = valid && (idx_e >= carg_e);
      KIND_BELOW: take = lt;
      KIND_ATUP:  take = valid && !lt;
      default:    take = 1'b0;
    endcase
  end

  assign term = take ? {{(SUM_W - KEY_W){key_q[KEY_W-1]}}, key_q} : '0;

  // Shift right on insert, left on erase, at and above the insert point
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      key_q <= prev_lt ? op.key : prev_key;
    end else if (ctl.era && !lt) begin
      key_q <= next_key;
    end
  end

endmodule

// ===== src/smrs_tree.sv =====
module smrs_tree (
  input  logic                              clk,
  input  logic                              lt   [smrs_pkg::CAPACITY],
  input  logic                              eq   [smrs_pkg::CAPACITY],
  input  logic signed [smrs_pkg::SUM_W-1:0] term [smrs_pkg::CAPACITY],
  output smrs_pkg::node_t                   root
);
  import smrs_pkg::*;

  node_t leaf [LEAVES];
  node_t lvl  [1:LEVELS][NODES];

  // Form leaves, padding past the last cell with zero
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_used
      assign leaf[j] = '{lt: CNT_W'(lt[j]), eq: eq[j], sum: term[j]};
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // Add four children per node, one register level per tree level
  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < NODES; j++) begin : g_node
      if (j < (LEAVES >> (2 * l))) begin : g_used
        if (l == 1) begin : g_first
          always_ff @(posedge clk) begin
            lvl[l][j] <= node_add4(leaf[4*j], leaf[4*j+1], leaf[4*j+2], leaf[4*j+3]);
          end
        end else begin : g_upper
          always_ff @(posedge clk) begin
            lvl[l][j] <= node_add4(lvl[l-1][4*j], lvl[l-1][4*j+1],
                                   lvl[l-1][4*j+2], lvl[l-1][4*j+3]);
          end
        end
      end else begin : g_idle
        always_ff @(posedge clk) begin
          lvl[l][j] <= '0;
        end
      end
    end
  end

  assign root = lvl[LEVELS][0];

endmodule

// ===== test/sorted_multiset_rank_sum_tb.sv =====
`timescale 1ns / 100ps

module sorted_multiset_rank_sum_tb;
  import smrs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 50;
  localparam int MIXED_ITEMS = 760;

  // One operation as sent on the slave stream
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    logic                    uniq;
    logic [ARG_W-1:0]        carg;
  } op_item_t;

  // One result as seen on the master stream
  typedef struct packed {
    logic                    found;
    logic [RANK_W-1:0]       rank;
    logic signed [KEY_W-1:0] key_out;
    logic signed [SUM_W-1:0] sum;
    logic                    status;
    logic [RANK_W-1:0]       occ;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  op_item_t pending_ops[$];
  result_t  expected_results[$];
  int       held_keys[$];
  op_item_t sent_op;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_cycles = 0;

  // Long quiet stretch early in the run on both sides
  wire steady_in  = n_accepted >= 300 && n_accepted < 650;
  wire steady_out = n_results >= 300 && n_results < 650;

  sorted_multiset_rank_sum DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (n_errors < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
    n_errors++;
  endtask

  // Apply one operation to the sorted key list and queue its result
  task automatic apply_to_multiset(input op_item_t op);
    result_t r;
    int kv;
    int n;
    int pos;
    int k;
    bit present;
    longint acc;
    r = '0;
    kv = op.key;
    n = held_keys.size();
    acc = 0;
    pos = 0;
    while (pos < n && held_keys[pos] < kv) pos++;
    present = pos < n && held_keys[pos] == kv;
    k = (op.carg < n) ? int'(op.carg) : n;
    case (op.kind)
      KIND_INS: begin
        r.found = present;
        r.rank = RANK_W'(pos);
        if (!(op.uniq && present)) begin
          if (n >= CAPACITY) r.status = 1'b1;
          else held_keys.insert(pos, kv);
        end
      end
      KIND_ERA: begin
        r.rank = RANK_W'(pos);
        if (present) begin
          held_keys.delete(pos);
          r.found = 1'b1;
        end
      end
      KIND_CLR: held_keys.delete();
      KIND_RANK: begin
        r.found = present;
        r.rank = RANK_W'(pos);
      end
      KIND_SEL: begin
        if (op.carg < n) begin
          r.found = 1'b1;
          r.key_out = held_keys[op.carg];
        end
      end
      KIND_FIRST: for (int i = 0; i < k; i++) acc += held_keys[i];
      KIND_FROM: for (int i = k; i < n; i++) acc += held_keys[i];
      KIND_BELOW: begin
        r.found = present;
        r.rank = RANK_W'(pos);
        for (int i = 0; i < pos; i++) acc += held_keys[i];
      end
      KIND_ATUP: begin
        r.found = present;
        r.rank = RANK_W'(pos);
        for (int i = pos; i < n; i++) acc += held_keys[i];
      end
      default: ;
    endcase
    r.sum = acc[SUM_W-1:0];
    r.occ = RANK_W'(held_keys.size());
    expected_results.insert(expected_results.size(), r);
  endtask

  // Stimulus helpers
  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] key,
                          input logic uniq, input logic [ARG_W-1:0] carg);
    op_item_t op;
    op.kind = kind;
    op.key = key;
    op.uniq = uniq;
    op.carg = carg;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // Favor a small set of keys so that duplicates and hits are common
  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 40) return $urandom;
    case ($urandom_range(0, 9))
      0: return KEY_MIN;
      1: return KEY_MIN + 1;
      2: return -1000;
      3: return -1;
      4: return 0;
      5: return 1;
      6: return 7;
      7: return 1000;
      8: return KEY_MAX - 1;
      default: return KEY_MAX;
    endcase
  endfunction

  function automatic logic [ARG_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ARG_W'($urandom_range(0, 40));
    if (r < 80) return ARG_W'(CAPACITY);
    return ARG_W'($urandom_range(0, CAPACITY));
  endfunction

  function automatic logic [KIND_W-1:0] pick_query();
    return KIND_W'($urandom_range(KIND_RANK, KIND_ATUP));
  endfunction

  // Driver: hold the item until taken, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_to_multiset(sent_op);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() != 0 && (steady_in || $urandom_range(0, 99) >= 25)) begin
          sent_op = pending_ops.pop_front();
          s_axis_tdata <= IN_DATA_W'({sent_op.carg, sent_op.uniq, sent_op.key});
          s_axis_tuser <= sent_op.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found   = m_axis_tdata[0];
        got.rank    = m_axis_tdata[11:1];
        got.key_out = m_axis_tdata[43:12];
        got.sum     = m_axis_tdata[85:44];
        got.status  = m_axis_tdata[86];
        got.occ     = m_axis_tdata[97:87];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, found", got.found, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.rank !== want.rank) report_mismatch("rank", got.rank, want.rank);
          if (got.key_out !== want.key_out)
            report_mismatch("key_out", got.key_out, want.key_out);
          if (got.sum !== want.sum) report_mismatch("sum_out", got.sum, want.sum);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.occ !== want.occ) report_mismatch("occupancy", got.occ, want.occ);
        end
        n_results++;
      end
      m_axis_tready <= steady_out || $urandom_range(0, 99) >= 25;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int grown;
    int r;
    int n_total;

    // Directed: empty store, extremes, duplicates, misses and unused kinds
    queue_op(KIND_SEL, 0, 1'b0, 0);
    queue_op(KIND_FIRST, 0, 1'b0, CAPACITY);
    queue_op(KIND_ERA, 5, 1'b0, 0);
    queue_op(KIND_RANK, KEY_MAX, 1'b0, 0);
    queue_op(KIND_INS, KEY_MAX, 1'b0, 0);
    queue_op(KIND_INS, KEY_MIN, 1'b0, 0);
    queue_op(KIND_INS, 0, 1'b0, 0);
    queue_op(KIND_INS, 0, 1'b0, 0);
    queue_op(KIND_INS, 0, 1'b1, 0);
    queue_op(KIND_INS, 5, 1'b1, 0);
    queue_op(KIND_RANK, 0, 1'b0, 0);
    queue_op(KIND_ERA, 0, 1'b0, 0);
    queue_op(KIND_ERA, 7, 1'b0, 0);
    queue_op(KIND_SEL, 0, 1'b0, 0);
    queue_op(KIND_SEL, 0, 1'b0, CAPACITY);
    queue_op(KIND_FIRST, 0, 1'b0, 2);
    queue_op(KIND_FROM, 0, 1'b0, 1);
    queue_op(KIND_FROM, 0, 1'b0, CAPACITY);
    queue_op(KIND_BELOW, 0, 1'b0, 0);
    queue_op(KIND_ATUP, 0, 1'b0, 0);
    queue_op(KIND_BELOW, KEY_MIN, 1'b0, 0);
    queue_op(KIND_ATUP, KEY_MAX, 1'b0, 0);
    queue_op(KIND_UNUSED_LO, KEY_MAX, 1'b1, CAPACITY);
    queue_op(KIND_UNUSED_HI, 3, 1'b0, 1);
    queue_op(KIND_CLR, 0, 1'b0, 0);
    queue_op(KIND_SEL, 0, 1'b0, 0);

    // Fill to capacity with plain inserts and scattered queries, then overflow
    grown = 0;
    while (grown < CAPACITY + 8) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_op(pick_query(), pick_key(), 1'b0, ARG_W'($urandom_range(0, CAPACITY)));
      end else begin
        queue_op(KIND_INS, pick_key(), 1'b0, ARG_W'($urandom));
        grown++;
      end
    end

    // Work around the full mark: erase, refill, rejected and unique inserts
    repeat (120) begin
      r = $urandom_range(0, 99);
      if (r < 40) queue_op(KIND_INS, pick_key(), 1'($urandom_range(0, 1)), ARG_W'($urandom));
      else if (r < 55)
        queue_op(KIND_ERA, pick_key(), 1'($urandom_range(0, 1)), ARG_W'($urandom));
      else queue_op(pick_query(), pick_key(), 1'($urandom_range(0, 1)),
                    ARG_W'($urandom_range(0, CAPACITY)));
    end

    // Mixed traffic on small stores with frequent clears
    queue_op(KIND_CLR, $urandom, 1'b1, CAPACITY);
    repeat (MIXED_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 35) queue_op(KIND_INS, pick_key(), $urandom_range(0, 99) < 30, pick_count());
      else if (r < 50)
        queue_op(KIND_ERA, pick_key(), 1'($urandom_range(0, 1)), pick_count());
      else if (r < 53)
        queue_op(KIND_CLR, pick_key(), 1'($urandom_range(0, 1)), pick_count());
      else if (r < 55)
        queue_op(KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), pick_key(),
                 1'($urandom_range(0, 1)), pick_count());
      else queue_op(pick_query(), pick_key(), 1'($urandom_range(0, 1)), pick_count());
    end
    n_total = pending_ops.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: all items taken, all results seen, then settle
    wait (n_accepted == n_total && n_results == n_total);
    repeat (20) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/smrs_pkg.sv
src/smrs_cell.sv
src/smrs_tree.sv
src/sorted_multiset_rank_sum.sv
test/sorted_multiset_rank_sum_tb.sv
